@@ rtl/cml_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cml_pkg
// Shared types, sizes and codes of the caliper match core.
// ----------------------------------------------------------------------------
package cml_pkg;

  // Store geometry
  localparam int MAX_CASES    = 1024;
  localparam int MAX_MEASURES = 4;
  localparam int IDX_W        = (MAX_CASES > 1) ? $clog2(MAX_CASES) : 1;
  localparam int COUNT_W      = $clog2(MAX_CASES + 1);

  // Field widths of the streams
  localparam int MEAS_W      = 32;
  localparam int IN_MEAS     = 4;
  localparam int OUT_IDX_W   = 10;
  localparam int OUT_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int NUM_THR     = 4;

  typedef logic [MEAS_W-1:0]                   measure_t;
  typedef measure_t [MAX_MEASURES-1:0]         row_t;
  typedef logic [MAX_MEASURES-1:0]             lane_mask_t;
  typedef logic [IDX_W-1:0]                    case_idx_t;

  // Input kinds
  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MATCH   = 2'd1,
    STATUS_NOMATCH = 2'd2,
    STATUS_FULL    = 2'd3
  } status_t;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MEASURES   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_THR_FIRST  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_THR_SECOND = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_THR_THIRD  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_THR_FOURTH = 3'd4;

  // Control into the compare unit
  typedef struct packed {
    logic      start;
    logic      row_valid;
    case_idx_t row_idx;
  } cmp_ctrl_t;

  // Status out of the compare unit
  typedef struct packed {
    logic      busy;
    logic      found;
    case_idx_t best_idx;
  } cmp_status_t;

  // Map a case index onto the output index field (low bits, zero filled)
  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input case_idx_t idx);
    logic [OUT_IDX_W+IDX_W-1:0] wide;
    wide = {{OUT_IDX_W{1'b0}}, idx};
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/caliper_match_lexicographic_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// caliper_match_lexicographic_core
// Case store with caliper matching of control queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one transaction per record; tuser holds the kind
//   (clear, load case, query control), tdata the four measures.
//   Output stream (m_axis): one transaction per input; tuser holds the status,
//   tdata the case index.
//   Config channel (cfg_*): register index and data, always ready; write
//   only while the core is idle.
// Sequencing:
//   Clear, load and unknown kinds go from idle to the done state and then
//   to the output register. A query scans the stored cases through one
//   compare unit at one case per cycle. The input is not ready while an
//   item is in work, so one item is in work at a time.
// Reset:
//   Empties the store (case count zero), sets one measure in use and all
//   thresholds to zero. The case rows themselves are not cleared.
// Stall:
//   A finished result waits in the output register; the next item is
//   accepted meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
module caliper_match_lexicographic_core
  import cml_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst,
  // Input stream; tdata: measure_one, measure_two, measure_three,
  // measure_four (32 bits each)
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [IN_MEAS*MEAS_W-1:0]    s_axis_tdata,
  // tuser: kind
  input  wire  [1:0]                   s_axis_tuser,
  // Output stream; tdata: case_index (10 bits), zero fill
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [OUT_DATA_W-1:0]        m_axis_tdata,
  // tuser: status
  output logic [1:0]                   m_axis_tuser,
  // Configuration write channel
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [CFG_INDEX_W-1:0]       cfg_index,
  input  wire  [CFG_DATA_W-1:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers
  logic [2:0]            measures_in_use;
  logic [NUM_THR-1:0][MEAS_W-1:0] thr_regs;

  // Store and scan control
  logic [COUNT_W-1:0]    case_count;
  logic [COUNT_W-1:0]    rd_ptr;
  logic                  rd_valid;
  case_idx_t             rd_idx;
  row_t                  control_row;
  row_t                  in_row;
  row_t                  case_row;
  row_t                  thresholds;
  lane_mask_t            lane_en;

  // Result held until the output register frees
  status_t               res_status;
  logic [OUT_IDX_W-1:0]  res_idx;

  logic                  in_accept;
  kind_t                 in_kind;
  logic                  store_full;
  logic                  ram_we;
  logic                  ram_re;
  logic                  start;
  logic [2:0]            nm;
  cmp_ctrl_t             cmp_ctrl;
  cmp_status_t           cmp_status;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_kind       = kind_t'(s_axis_tuser);
  assign store_full    = (case_count >= COUNT_W'(MAX_CASES));

  // Unpack the record into a row of measures
  always_comb begin
    for (int q = 0; q < MAX_MEASURES; q++) begin
      in_row[q] = s_axis_tdata[q*MEAS_W +: MEAS_W];
    end
  end

  // Clamp the measure count and build the lane mask
  always_comb begin
    if (measures_in_use == 3'd0) begin
      nm = 3'd1;
    end else if (measures_in_use > 3'(MAX_MEASURES)) begin
      nm = 3'(MAX_MEASURES);
    end else begin
      nm = measures_in_use;
    end
    for (int q = 0; q < MAX_MEASURES; q++) begin
      lane_en[q]    = (3'(q) < nm);
      thresholds[q] = thr_regs[q];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      measures_in_use <= 3'd1;
      thr_regs        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MEASURES:   measures_in_use <= cfg_data[2:0];
        CFG_THR_FIRST:  thr_regs[0]     <= cfg_data;
        CFG_THR_SECOND: thr_regs[1]     <= cfg_data;
        CFG_THR_THIRD:  thr_regs[2]     <= cfg_data;
        CFG_THR_FOURTH: thr_regs[3]     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ram_we = in_accept && (in_kind == KIND_LOAD) && !store_full;
  assign ram_re = (state == S_SCAN) && (rd_ptr < case_count);
  assign start  = in_accept && (in_kind == KIND_QUERY);

  cml_case_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (case_count[IDX_W-1:0]),
    .wdata (in_row),
    .re    (ram_re),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (case_row)
  );

  // Track the registered read alongside its index
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_ptr[IDX_W-1:0];
  end

  assign cmp_ctrl.start     = start;
  assign cmp_ctrl.row_valid = rd_valid;
  assign cmp_ctrl.row_idx   = rd_idx;

  cml_compare_unit u_cmp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (cmp_ctrl),
    .case_row    (case_row),
    .control_row (control_row),
    .thresholds  (thresholds),
    .lane_en     (lane_en),
    .status      (cmp_status)
  );

  // Hold the control measures for the scan
  always_ff @(posedge clk) begin
    if (start) begin
      control_row <= in_row;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      case_count    <= '0;
      rd_ptr        <= '0;
      res_status    <= STATUS_OK;
      res_idx       <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tuser  <= '0;
      m_axis_tdata  <= '0;
    end else begin
      // Drop the output once taken
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            case (in_kind)
              KIND_CLEAR: begin
                case_count <= '0;
                res_status <= STATUS_OK;
                res_idx    <= '0;
                state      <= S_DONE;
              end
              KIND_LOAD: begin
                state <= S_DONE;
                if (store_full) begin
                  res_status <= STATUS_FULL;
                  res_idx    <= '0;
                end else begin
                  res_status <= STATUS_OK;
                  res_idx    <= to_out_idx(case_count[IDX_W-1:0]);
                  case_count <= case_count + 1'b1;
                end
              end
              KIND_QUERY: begin
                rd_ptr <= '0;
                state  <= S_SCAN;
              end
              default: begin
                res_status <= STATUS_OK;
                res_idx    <= '0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (ram_re) begin
            rd_ptr <= rd_ptr + 1'b1;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // Wait for the last case to pass the compare unit
          if (!rd_valid && !cmp_status.busy) begin
            if (cmp_status.found) begin
              res_status <= STATUS_MATCH;
              res_idx    <= to_out_idx(cmp_status.best_idx);
            end else begin
              res_status <= STATUS_NOMATCH;
              res_idx    <= '0;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_status;
            m_axis_tdata  <= {{(OUT_DATA_W-OUT_IDX_W){1'b0}}, res_idx};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/cml_case_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cml_case_ram
// Case store: one row of measures per case, one write and one registered
// read port.
// ----------------------------------------------------------------------------
module cml_case_ram
  import cml_pkg::*;
(
  input  wire       clk,
  input  wire       we,
  input  case_idx_t waddr,
  input  row_t      wdata,
  input  wire       re,
  input  case_idx_t raddr,
  output row_t      rdata
);

  row_t mem [MAX_CASES];

  // Write a whole case row
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/cml_compare_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cml_compare_unit
// Shared distance and ranking unit: takes one stored case per cycle, forms
// the absolute differences to the control, checks the calipers and keeps
// the lexicographically smallest eligible difference vector.
// ----------------------------------------------------------------------------
module cml_compare_unit
  import cml_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  cmp_ctrl_t   ctrl,
  input  row_t        case_row,
  input  row_t        control_row,
  input  row_t        thresholds,
  input  lane_mask_t  lane_en,
  output cmp_status_t status
);

  // Difference stage registers
  logic      diff_valid;
  case_idx_t diff_idx;
  row_t      diff;
  row_t      diff_next;

  // Best match registers
  logic      found;
  case_idx_t best_idx;
  row_t      best;

  logic       eligible;
  logic       less;
  logic       decided;
  lane_mask_t over;

  // Absolute difference per lane; disabled lanes read as zero
  always_comb begin
    for (int q = 0; q < MAX_MEASURES; q++) begin
      if (!lane_en[q]) begin
        diff_next[q] = '0;
      end else if ($signed(case_row[q]) < $signed(control_row[q])) begin
        diff_next[q] = control_row[q] - case_row[q];
      end else begin
        diff_next[q] = case_row[q] - control_row[q];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
    end else begin
      diff_valid <= ctrl.row_valid && !ctrl.start;
    end
  end

  always_ff @(posedge clk) begin
    diff     <= diff_next;
    diff_idx <= ctrl.row_idx;
  end

  // Caliper check and lexicographic compare against the best so far
  always_comb begin
    for (int q = 0; q < MAX_MEASURES; q++) begin
      over[q] = diff[q] > thresholds[q];
    end
    eligible = (over == '0);
    less     = 1'b0;
    decided  = 1'b0;
    for (int q = 0; q < MAX_MEASURES; q++) begin
      if (!decided && diff[q] != best[q]) begin
        decided = 1'b1;
        less    = diff[q] < best[q];
      end
    end
  end

  // Keep the winner; strict less leaves ties with the lower index
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.start) begin
      found <= 1'b0;
    end else if (diff_valid && eligible && (!found || less)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctrl.start && diff_valid && eligible && (!found || less)) begin
      best     <= diff;
      best_idx <= diff_idx;
    end
  end

  assign status.busy     = diff_valid;
  assign status.found    = found;
  assign status.best_idx = best_idx;

endmodule
`default_nettype wire
